/* rtl/seven_segment_number_frame_defines.svh */
// Assertion macros shared by the seven-segment frame encoder modules
`ifndef SEVEN_SEGMENT_NUMBER_FRAME_DEFINES_SVH
`define SEVEN_SEGMENT_NUMBER_FRAME_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define SSNF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define SSNF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ssnf_pkg.sv */
// Types, constants and segment tables of the seven-segment frame encoder
package ssnf_pkg;

  localparam int MAX_DIGITS = 4;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int BYTE_W     = CNT_W + 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_FIRST = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_LAST  = 1'b1;
  localparam logic [7:0] WIDE_FIRST_RST = 8'd36;
  localparam logic [7:0] WIDE_LAST_RST  = 8'd48;

  // q / 10 == (q * RECIP10) >> RECIP_SHIFT for every q below 2^15
  localparam int Q_W         = 15;
  localparam int QUOT_W      = 12;
  localparam int PROD_W      = 31;
  localparam int RECIP_SHIFT = 19;
  localparam logic [15:0] RECIP10 = 16'd52429;

  localparam logic signed [15:0] DASH_VALUE = -16'sd45;
  localparam logic [15:0] NARROW_DASH = 16'h0004;
  localparam logic [15:0] WIDE_DASH   = 16'h0204;

  typedef struct packed {
    logic [7:0]                  addr;
    logic [CNT_W-1:0]            n;
    logic [MAX_DIGITS-1:0][15:0] pos;
  } frame_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [15:0] narrow_pat(input logic [3:0] d);
    logic [15:0] p;
    unique case (d)
      4'd0:    p = 16'h00F3;
      4'd1:    p = 16'h0060;
      4'd2:    p = 16'h00B5;
      4'd3:    p = 16'h00F4;
      4'd4:    p = 16'h0066;
      4'd5:    p = 16'h00D6;
      4'd6:    p = 16'h00D7;
      4'd7:    p = 16'h0070;
      4'd8:    p = 16'h00F7;
      4'd9:    p = 16'h00F6;
      default: p = 16'h0000;
    endcase
    return p;
  endfunction

  function automatic logic [15:0] wide_pat(input logic [3:0] d);
    logic [15:0] p;
    unique case (d)
      4'd0:    p = 16'hF1FB;
      4'd1:    p = 16'h3060;
      4'd2:    p = 16'hD2BD;
      4'd3:    p = 16'h72FC;
      4'd4:    p = 16'h3366;
      4'd5:    p = 16'h63DE;
      4'd6:    p = 16'hE3DF;
      4'd7:    p = 16'h3078;
      4'd8:    p = 16'hF3FF;
      4'd9:    p = 16'h73FE;
      default: p = 16'h0000;
    endcase
    return p;
  endfunction

endpackage

/* rtl/ssnf_in_if.sv */
// Input channel: start address, value, digit count and leading-zero flag
interface ssnf_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         start_address;
  logic signed [15:0] value;
  logic [2:0]         digit_count;
  logic               pad_zeros;

  modport source (output valid, start_address, value, digit_count, pad_zeros, input ready);
  modport sink   (input valid, start_address, value, digit_count, pad_zeros, output ready);
endinterface

/* rtl/ssnf_out_if.sv */
// Result channel: one frame byte per beat with a last-byte flag
interface ssnf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

/* rtl/ssnf_front.sv */
// Front end: window registers, item classification and digit conversion
module ssnf_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [ssnf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                  cfg_data,
  ssnf_in_if.sink                     in_ch,
  input  ssnf_pkg::q_stat_t           q_stat,
  output logic                        q_push,
  output ssnf_pkg::frame_desc_t       q_wdata
);
  import ssnf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [7:0]                  win_first_r, win_last_r;
  logic [7:0]                  addr_r, addr_nxt;
  logic [CNT_W-1:0]            n_r, n_nxt;
  logic [CNT_W-1:0]            k_r, k_nxt;
  logic                        lz_r, lz_nxt;
  logic                        wide_r, wide_nxt;
  logic [Q_W-1:0]              q_r, q_nxt;
  logic [MAX_DIGITS-1:0][15:0] pos_r, pos_nxt;

  logic [CNT_W-1:0]            n_sat;
  logic                        in_wide;
  logic [MAX_DIGITS-1:0][15:0] dash_pos;
  logic [PROD_W-1:0]           prod;
  logic [QUOT_W-1:0]           quot;
  logic [Q_W-1:0]              tenq;
  logic [Q_W-1:0]              rem_full;
  logic [3:0]                  rem;
  logic [CNT_W-1:0]            km1;

  assign in_ch.ready = (state_r == ST_IDLE);

  assign n_sat = (int'(in_ch.digit_count) > MAX_DIGITS) ? CNT_W'(MAX_DIGITS)
                                                        : CNT_W'(in_ch.digit_count);
  assign in_wide = (in_ch.start_address >= win_first_r) &&
                   (in_ch.start_address <= win_last_r);

  // Dashes fill the rightmost positions; wide window without leading zeros keeps two
  always_comb begin
    int drawn;
    drawn = int'(n_sat);
    if (in_wide && !in_ch.pad_zeros && drawn > 2) begin
      drawn = 2;
    end
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (i < int'(n_sat) && i >= int'(n_sat) - drawn) begin
        dash_pos[i] = in_wide ? WIDE_DASH : NARROW_DASH;
      end else begin
        dash_pos[i] = 16'h0000;
      end
    end
  end

  // One decimal digit per cycle through a reciprocal multiply
  assign prod     = PROD_W'(q_r) * PROD_W'(RECIP10);
  assign quot     = prod[RECIP_SHIFT +: QUOT_W];
  assign tenq     = Q_W'({quot, 3'b000}) + Q_W'({quot, 1'b0});
  assign rem_full = q_r - tenq;
  assign rem      = rem_full[3:0];
  assign km1      = k_r - 1'b1;

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    lz_nxt    = lz_r;
    wide_nxt  = wide_r;
    q_nxt     = q_r;
    pos_nxt   = pos_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          addr_nxt = in_ch.start_address;
          n_nxt    = n_sat;
          k_nxt    = n_sat;
          lz_nxt   = in_ch.pad_zeros;
          wide_nxt = in_wide;
          q_nxt    = in_ch.value[Q_W-1:0];
          pos_nxt  = '0;
          if (in_ch.value[15]) begin
            if (in_ch.value == DASH_VALUE) begin
              pos_nxt = dash_pos;
            end
            state_nxt = ST_PUSH;
          end else if (n_sat == '0) begin
            state_nxt = ST_PUSH;
          end else begin
            state_nxt = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        pos_nxt[km1[IDX_W-1:0]] = wide_r ? wide_pat(rem) : narrow_pat(rem);
        q_nxt = Q_W'(quot);
        k_nxt = km1;
        // stop at the leftmost position, or once the quotient runs out without leading zeros
        if (km1 == '0 || (!lz_r && quot == '0)) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!q_stat.full) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign q_push       = (state_r == ST_PUSH) && !q_stat.full;
  assign q_wdata.addr = addr_r;
  assign q_wdata.n    = n_r;
  assign q_wdata.pos  = pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_first_r <= WIDE_FIRST_RST;
      win_last_r  <= WIDE_LAST_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WIDE_FIRST: win_first_r <= cfg_data;
          REG_WIDE_LAST:  win_last_r  <= cfg_data;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    n_r    <= n_nxt;
    k_r    <= k_nxt;
    lz_r   <= lz_nxt;
    wide_r <= wide_nxt;
    q_r    <= q_nxt;
    pos_r  <= pos_nxt;
  end

endmodule

/* rtl/ssnf_queue.sv */
// Short queue of frame descriptors between front end and byte serializer
`include "seven_segment_number_frame_defines.svh"

module ssnf_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  ssnf_pkg::frame_desc_t wdata,
  input  logic                  pop,
  output ssnf_pkg::frame_desc_t rdata,
  output ssnf_pkg::q_stat_t     stat
);
  import ssnf_pkg::*;

  frame_desc_t       mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  assign stat.full  = (int'(cnt_r) == QUEUE_DEPTH);
  assign stat.empty = (cnt_r == '0);
  assign rdata      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `SSNF_ASSERT_IMP(a_no_overflow, push, !stat.full || pop, "descriptor pushed into full queue")
  `SSNF_ASSERT_IMP(a_no_underflow, pop, !stat.empty, "descriptor popped from empty queue")

endmodule

/* rtl/ssnf_back.sv */
// Back end: serializes one frame descriptor into address and segment bytes
`include "seven_segment_number_frame_defines.svh"

module ssnf_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ssnf_pkg::frame_desc_t q_rdata,
  input  ssnf_pkg::q_stat_t     q_stat,
  output logic                  q_pop,
  ssnf_out_if.source            out_ch
);
  import ssnf_pkg::*;

  logic              busy_r;
  frame_desc_t       desc_r;
  logic [BYTE_W-1:0] cnt_r;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_last_r;

  logic              emit;
  logic              last;
  logic [BYTE_W-1:0] last_cnt;
  logic [BYTE_W-1:0] cnt_m1;
  logic [15:0]       cur_pos;
  logic [7:0]        sel_byte;

  // byte 0 is the address, then low and high byte of each position
  assign last_cnt = {desc_r.n, 1'b0};
  assign cnt_m1   = cnt_r - 1'b1;
  assign cur_pos  = desc_r.pos[cnt_m1[IDX_W:1]];
  assign sel_byte = (cnt_r == '0) ? desc_r.addr :
                    (cnt_r[0] ? cur_pos[7:0] : cur_pos[15:8]);
  assign last     = (cnt_r == last_cnt);

  // advance when the output register is free or its beat is taken
  assign emit  = busy_r && (!out_valid_r || out_ch.ready);
  assign q_pop = !busy_r && !q_stat.empty;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.frame_byte = out_byte_r;
  assign out_ch.last_byte  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
      end else if (emit && last) begin
        busy_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      desc_r <= q_rdata;
      cnt_r  <= '0;
    end else if (emit) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (emit) begin
      out_byte_r <= sel_byte;
      out_last_r <= last;
    end
  end

  `SSNF_ASSERT_IMP(a_pop_when_idle, q_pop, !busy_r, "descriptor loaded while a frame is in flight")
  `SSNF_ASSERT_IMP(a_cnt_in_frame, busy_r, cnt_r <= last_cnt, "byte counter ran past the frame")
  `SSNF_ASSERT_NEXT(a_last_ends_frame, emit && last, !busy_r && out_last_r, "frame did not close on its last byte")

endmodule

/* rtl/seven_segment_number_frame.sv */
// Path: with the back end idle, an input beat passes the conversion state once per digit
// converted (at most n, none for negative values or zero count), the push state, the queue,
// desc_r and the output register. Throughput: one byte per cycle within a frame while the
// sink is ready; a 2n + 1 byte frame holds the serializer until its last byte is out.
// The front end converts one digit per cycle with a reciprocal multiplier.
// Reset: window registers return to 36..48, the descriptor queue empties, no beat pending.
module seven_segment_number_frame (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ssnf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  ssnf_in_if.sink                        in_ch,
  ssnf_out_if.source                     out_ch
);
  import ssnf_pkg::*;

  q_stat_t     q_stat;
  logic        q_push;
  logic        q_pop;
  frame_desc_t q_wdata;
  frame_desc_t q_rdata;

  ssnf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  ssnf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  ssnf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_rdata (q_rdata),
    .q_stat  (q_stat),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

/* tb/tb.sv */
// Testbench for the seven-segment number frame encoder: directed table, random phases, checker
module tb;
  import ssnf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_beat_t;

  typedef struct packed {
    logic [7:0]        addr;
    logic signed [15:0] value;
    logic [2:0]        count;
    logic              pad_zeros;
    logic [3:0]        n_typed;
    logic [0:8][7:0]   typed;
  } stim_row_t;

  localparam int DIR_ROWS = 23;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0] cfg_data;

  ssnf_in_if  in_ch ();
  ssnf_out_if out_ch ();

  seven_segment_number_frame uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  frame_beat_t expected_bytes [$];
  logic [7:0]  win_first;
  logic [7:0]  win_last;
  int          err_count;
  int          items_sent;
  int          bytes_checked;
  int          window_settings;
  int          cycle_count;
  bit          tx_quiet;
  bit          rx_quiet;
  bit          rx_long_hold;
  stim_row_t   dir_rows [DIR_ROWS];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Segment set per decimal digit, bit 0 = a up to bit 6 = g
  function automatic logic [6:0] digit_segments(input int unsigned d);
    case (d)
      0:       return 7'h3F;
      1:       return 7'h06;
      2:       return 7'h5B;
      3:       return 7'h4F;
      4:       return 7'h66;
      5:       return 7'h6D;
      6:       return 7'h7D;
      7:       return 7'h07;
      8:       return 7'h7F;
      default: return 7'h6F;
    endcase
  endfunction

  // Panel wiring of each segment; the wide form drives a second bit per segment
  function automatic logic [15:0] segment_bits(input int s, input logic wide);
    logic [15:0] narrow_bit;
    logic [15:0] extra_bit;
    case (s)
      0:       begin narrow_bit = 16'h0010; extra_bit = 16'h0008; end
      1:       begin narrow_bit = 16'h0020; extra_bit = 16'h1000; end
      2:       begin narrow_bit = 16'h0040; extra_bit = 16'h2000; end
      3:       begin narrow_bit = 16'h0080; extra_bit = 16'h4000; end
      4:       begin narrow_bit = 16'h0001; extra_bit = 16'h8000; end
      5:       begin narrow_bit = 16'h0002; extra_bit = 16'h0100; end
      default: begin narrow_bit = 16'h0004; extra_bit = 16'h0200; end
    endcase
    return wide ? (narrow_bit | extra_bit) : narrow_bit;
  endfunction

  function automatic logic [15:0] cell_pattern(input logic [6:0] segs, input logic wide);
    logic [15:0] p;
    p = 16'h0000;
    for (int s = 0; s < 7; s++)
      if (segs[s]) p |= segment_bits(s, wide);
    return p;
  endfunction

  // Work out the frame bytes for one input beat and queue them
  function automatic void predict_frame(input logic [7:0] addr, input logic signed [15:0] val,
                                        input logic [2:0] cnt, input logic lz);
    logic [15:0] cells [MAX_DIGITS];
    int unsigned n;
    int unsigned q;
    int unsigned drawn;
    logic wide;
    frame_beat_t b;
    wide = (addr >= win_first) && (addr <= win_last);
    n = (cnt > MAX_DIGITS) ? MAX_DIGITS : cnt;
    for (int k = 0; k < MAX_DIGITS; k++) cells[k] = 16'h0000;
    if (!val[15]) begin
      q = val[14:0];
      for (int k = n; k > 0; k--) begin
        cells[k-1] = cell_pattern(digit_segments(q % 10), wide);
        q = q / 10;
        if (!lz && q == 0) break;
      end
    end else if (val == DASH_VALUE) begin
      drawn = n;
      if (wide && !lz && drawn > 2) drawn = 2;
      for (int k = 0; k < drawn; k++) cells[n-1-k] = cell_pattern(7'h40, wide);
    end
    b.frame_byte = addr;
    b.last_byte  = (n == 0);
    expected_bytes.push_back(b);
    for (int k = 0; k < n; k++) begin
      b.frame_byte = cells[k][7:0];
      b.last_byte  = 1'b0;
      expected_bytes.push_back(b);
      b.frame_byte = cells[k][15:8];
      b.last_byte  = (k == n - 1);
      expected_bytes.push_back(b);
    end
  endfunction

  // Present one item after a random gap unless tx_quiet is set; returns at the accepting edge
  task automatic send_item(input logic [7:0] addr, input logic signed [15:0] val,
                           input logic [2:0] cnt, input logic lz);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.start_address <= addr;
    in_ch.value         <= val;
    in_ch.digit_count   <= cnt;
    in_ch.pad_zeros     <= lz;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Drop valid and wait until every queued byte has come back
  task automatic drain_frames();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
  endtask

  task automatic write_window(input logic [7:0] first_addr, input logic [7:0] last_addr);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WIDE_FIRST;
    cfg_data  <= first_addr;
    @(negedge clk);
    cfg_index <= REG_WIDE_LAST;
    cfg_data  <= last_addr;
    @(negedge clk);
    cfg_we    <= 1'b0;
    win_first = first_addr;
    win_last  = last_addr;
    window_settings++;
  endtask

  task automatic run_phase(input logic [7:0] first_addr, input logic [7:0] last_addr,
                           input int n_items, input bit quiet_tx, input bit quiet_rx,
                           input bit hold_off);
    logic [7:0]        addr;
    logic signed [15:0] val;
    logic [2:0]        cnt;
    logic              lz;
    write_window(first_addr, last_addr);
    tx_quiet = quiet_tx;
    rx_quiet = quiet_rx;
    rx_long_hold = hold_off;
    for (int i = 0; i < n_items; i++) begin
      // aim half the addresses at the window edges
      case ($urandom_range(0, 7))
        0:       addr = win_first - 8'd1;
        1:       addr = win_first;
        2:       addr = win_last;
        3:       addr = win_last + 8'd1;
        default: addr = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: val = 16'($urandom_range(0, 9999));
        4:          val = 16'($urandom_range(0, 32767));
        5, 6:       val = DASH_VALUE;
        7:          val = 16'($urandom);
        8:          val = 16'($urandom_range(0, 99));
        default: begin
          case ($urandom_range(0, 5))
            0:       val = 16'sd0;
            1:       val = 16'sh7FFF;
            2:       val = 16'sh8000;
            3:       val = -16'sd1;
            4:       val = -16'sd44;
            default: val = -16'sd46;
          endcase
        end
      endcase
      cnt = 3'(($urandom_range(0, 6) != 0) ? $urandom_range(1, 4) : $urandom_range(0, 7));
      lz  = 1'($urandom_range(0, 1));
      send_item(addr, val, cnt, lz);
      predict_frame(addr, val, cnt, lz);
    end
    drain_frames();
  endtask

  // Receiver: random hold before each beat unless rx_quiet is set, one long hold-off on request
  initial begin
    int hold;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      hold = rx_quiet ? 0 : $urandom_range(0, 9);
      if (rx_long_hold) begin
        hold = LONG_HOLD;
        rx_long_hold = 1'b0;
      end
      repeat (hold) begin
        out_ch.ready <= 1'b0;
        @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    frame_beat_t exp_beat;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        $error("frame_byte: expected none, got %02h (last_byte %0b)",
               out_ch.frame_byte, out_ch.last_byte);
        err_count++;
      end else begin
        exp_beat = expected_bytes.pop_front();
        bytes_checked++;
        if (out_ch.frame_byte !== exp_beat.frame_byte) begin
          $error("frame_byte: expected %02h, got %02h", exp_beat.frame_byte, out_ch.frame_byte);
          err_count++;
        end
        if (out_ch.last_byte !== exp_beat.last_byte) begin
          $error("last_byte: expected %0b, got %0b", exp_beat.last_byte, out_ch.last_byte);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still due", cycle_count,
               expected_bytes.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    frame_beat_t b;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = REG_WIDE_FIRST;
    cfg_data            = 8'h00;
    in_ch.valid         = 1'b0;
    in_ch.start_address = 8'h00;
    in_ch.value         = 16'sd0;
    in_ch.digit_count   = 3'd0;
    in_ch.pad_zeros     = 1'b0;
    err_count       = 0;
    items_sent      = 0;
    bytes_checked   = 0;
    window_settings = 1;
    cycle_count     = 0;
    tx_quiet        = 1'b0;
    rx_quiet        = 1'b0;
    rx_long_hold    = 1'b0;
    win_first       = WIDE_FIRST_RST;
    win_last        = WIDE_LAST_RST;

    // addr, value, count, pad_zeros, typed byte count, typed frame (window at reset)
    dir_rows[0]  = '{8'h00, -16'sd1,     3'd2, 1'b1, 4'd5, 72'h00_00_00_00_00_00_00_00_00};
    dir_rows[1]  = '{8'hFF, 16'sd123,    3'd0, 1'b1, 4'd1, 72'hFF_00_00_00_00_00_00_00_00};
    dir_rows[2]  = '{8'h10, -16'sd45,    3'd3, 1'b0, 4'd7, 72'h10_04_00_04_00_04_00_00_00};
    dir_rows[3]  = '{8'h24, -16'sd45,    3'd4, 1'b0, 4'd9, 72'h24_00_00_00_00_04_02_04_02};
    dir_rows[4]  = '{8'h00, 16'sd0,      3'd4, 1'b0, 4'd9, 72'h00_00_00_00_00_00_00_F3_00};
    dir_rows[5]  = '{8'h80, 16'sh8000,   3'd4, 1'b1, 4'd9, 72'h80_00_00_00_00_00_00_00_00};
    dir_rows[6]  = '{8'h30, 16'sh7FFF,   3'd4, 1'b1, 4'd0, 72'h0};
    dir_rows[7]  = '{8'h23, 16'sh7FFF,   3'd4, 1'b0, 4'd0, 72'h0};
    dir_rows[8]  = '{8'h31, 16'sd1234,   3'd4, 1'b0, 4'd0, 72'h0};
    dir_rows[9]  = '{8'h24, 16'sd5678,   3'd4, 1'b1, 4'd0, 72'h0};
    dir_rows[10] = '{8'h24, 16'sd9,      3'd1, 1'b0, 4'd0, 72'h0};
    dir_rows[11] = '{8'h25, 16'sd90,     3'd3, 1'b0, 4'd0, 72'h0};
    dir_rows[12] = '{8'h2A, -16'sd45,    3'd4, 1'b1, 4'd0, 72'h0};
    dir_rows[13] = '{8'h2A, -16'sd45,    3'd1, 1'b0, 4'd0, 72'h0};
    dir_rows[14] = '{8'h00, -16'sd45,    3'd2, 1'b1, 4'd0, 72'h0};
    dir_rows[15] = '{8'h40, 16'sd12345,  3'd7, 1'b0, 4'd0, 72'h0};
    dir_rows[16] = '{8'h40, 16'sd67,     3'd5, 1'b1, 4'd0, 72'h0};
    dir_rows[17] = '{8'h30, 16'sd0,      3'd6, 1'b1, 4'd0, 72'h0};
    dir_rows[18] = '{8'h24, -16'sd2,     3'd3, 1'b0, 4'd0, 72'h0};
    dir_rows[19] = '{8'hFF, 16'sd13579,  3'd2, 1'b0, 4'd0, 72'h0};
    dir_rows[20] = '{8'h00, 16'sd24680,  3'd4, 1'b1, 4'd0, 72'h0};
    dir_rows[21] = '{8'h01, 16'sd7,      3'd0, 1'b0, 4'd0, 72'h0};
    dir_rows[22] = '{8'h30, -16'sd45,    3'd0, 1'b0, 4'd0, 72'h0};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      send_item(dir_rows[r].addr, dir_rows[r].value, dir_rows[r].count, dir_rows[r].pad_zeros);
      if (dir_rows[r].n_typed == 0) begin
        predict_frame(dir_rows[r].addr, dir_rows[r].value, dir_rows[r].count,
                      dir_rows[r].pad_zeros);
      end else begin
        for (int k = 0; k < dir_rows[r].n_typed; k++) begin
          b.frame_byte = dir_rows[r].typed[k];
          b.last_byte  = (k == dir_rows[r].n_typed - 1);
          expected_bytes.push_back(b);
        end
      end
    end
    drain_frames();

    run_phase(8'd0,   8'd255, 60, 1'b0, 1'b0, 1'b0);
    run_phase(8'd255, 8'd0,   60, 1'b1, 1'b1, 1'b0);
    run_phase(8'd0,   8'd0,   50, 1'b0, 1'b0, 1'b0);
    // hold the output off for a long stretch while items keep coming
    run_phase(8'd255, 8'd255, 50, 1'b1, 1'b0, 1'b1);
    run_phase(8'd100, 8'd180, 60, 1'b0, 1'b0, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 40, 1'b0, 1'b1, 1'b0);
    run_phase(WIDE_FIRST_RST, WIDE_LAST_RST, 40, 1'b1, 1'b0, 1'b0);

    repeat (30) @(negedge clk);
    $display("Sent %0d numbers under %0d wide-window settings; %0d frame bytes compared.",
             items_sent, window_settings, bytes_checked);
    $display("Covered dashes, blanked negatives, zero and oversized digit counts, both zero modes.");
    if (err_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/ssnf_pkg.sv
rtl/ssnf_in_if.sv
rtl/ssnf_out_if.sv
rtl/ssnf_front.sv
rtl/ssnf_queue.sv
rtl/ssnf_back.sv
rtl/seven_segment_number_frame.sv
tb/tb.sv
